[sv/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache package
// Shared constants, codes and types of the retransmit cache blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

    localparam int CACHE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(CACHE_SLOTS);
    localparam int SEQ_W       = 16;
    localparam int HANDLE_W    = 16;
    localparam int SSRC_W      = 32;
    localparam int PT_W        = 7;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_SKIPPED    = 3'd1,
        ST_RETRANSMIT = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_MISMATCH   = 3'd4,
        ST_HIT_NO_RTX = 3'd5
    } status_t;

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_NACK  = 1'b1
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NACK_ENABLE      = 2'd0,
        CFG_RTX_STREAM_ID    = 2'd1,
        CFG_RTX_PAYLOAD_KIND = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              nack_enable;
        logic [SSRC_W-1:0] rtx_stream_id;
        logic [PT_W-1:0]   rtx_payload_kind;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [SEQ_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    function automatic logic rtx_on(input cfg_t cfg);
        return (cfg.rtx_stream_id != '0) && (cfg.rtx_payload_kind != '0);
    endfunction

    function automatic logic store_on(input cfg_t cfg);
        return cfg.nack_enable && rtx_on(cfg);
    endfunction

endpackage

`default_nettype wire

[sv/rtc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache configuration registers
// Holds the NACK enable and the RTX stream settings written over the
// configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_cfg_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rtc_pkg::SSRC_W-1:0]    cfg_data,
    output rtc_pkg::cfg_t                      cfg
);

    rtc_pkg::cfg_t cfg_reg;
    rtc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (rtc_pkg::cfg_idx_t'(cfg_index))
                rtc_pkg::CFG_NACK_ENABLE:
                    cfg_next.nack_enable = cfg_data[0];
                rtc_pkg::CFG_RTX_STREAM_ID:
                    cfg_next.rtx_stream_id = cfg_data;
                rtc_pkg::CFG_RTX_PAYLOAD_KIND:
                    cfg_next.rtx_payload_kind = cfg_data[rtc_pkg::PT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[sv/rtc_slot_mem.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache slot memory
// One-write, one-read memory of cache entries with a registered read port
// and a clearing pass over all slots after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_slot_mem
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [rtc_pkg::SLOT_W-1:0] wr_addr,
    input  wire rtc_pkg::entry_t            wr_entry,
    input  wire logic                       rd_en,
    input  wire logic [rtc_pkg::SLOT_W-1:0] rd_addr,
    output rtc_pkg::entry_t                 rd_entry,
    output logic                            clearing
);

    localparam logic [rtc_pkg::SLOT_W-1:0] LAST_SLOT =
        rtc_pkg::SLOT_W'(rtc_pkg::CACHE_SLOTS - 1);

    rtc_pkg::entry_t mem [rtc_pkg::CACHE_SLOTS];

    logic                       clearing_reg;
    logic                       clearing_next;
    logic [rtc_pkg::SLOT_W-1:0] clr_addr_reg;
    logic [rtc_pkg::SLOT_W-1:0] clr_addr_next;
    rtc_pkg::entry_t            rd_entry_reg;

    logic                       mem_we;
    logic [rtc_pkg::SLOT_W-1:0] mem_addr;
    rtc_pkg::entry_t            mem_data;

    assign clearing = clearing_reg;
    assign rd_entry = rd_entry_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_SLOT)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The clearing pass owns the write port; no item is taken meanwhile.
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_reg;
            mem_data = '0;
        end
        else
        begin
            mem_we   = wr_en;
            mem_addr = wr_addr;
            mem_data = wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/rtc_resolve.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache request resolution
// Holds the request beside the registered slot read, decides the status,
// advances the retransmit counter and keeps the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_resolve
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         req_type,
    input  wire logic [rtc_pkg::SEQ_W-1:0]    seq_num,
    input  wire rtc_pkg::entry_t              slot_entry,
    input  wire rtc_pkg::cfg_t                cfg,
    output logic                              hold,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [2:0]                        status,
    output logic [rtc_pkg::HANDLE_W-1:0]      found_handle,
    output logic [rtc_pkg::SEQ_W-1:0]         rtx_seq_out,
    output logic [rtc_pkg::SEQ_W-1:0]         echo_seq
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    rtc_pkg::req_t                 s1_req_reg;
    logic [rtc_pkg::SEQ_W-1:0]     s1_seq_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    rtc_pkg::status_t              status_reg;
    logic [rtc_pkg::HANDLE_W-1:0]  found_reg;
    logic [rtc_pkg::SEQ_W-1:0]     rtx_seq_reg;
    logic [rtc_pkg::SEQ_W-1:0]     echo_reg;

    logic [rtc_pkg::SEQ_W-1:0]     counter_reg;
    logic [rtc_pkg::SEQ_W-1:0]     counter_next;

    logic                          advance;
    logic [rtc_pkg::SEQ_W-1:0]     counter_inc;
    rtc_pkg::status_t              res_status;
    logic [rtc_pkg::HANDLE_W-1:0]  res_found;
    logic [rtc_pkg::SEQ_W-1:0]     res_rtx_seq;

    assign advance     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign hold        = s1_valid_reg && !advance;
    assign counter_inc = counter_reg + 1'b1;

    always_comb
    begin
        res_status   = rtc_pkg::ST_SKIPPED;
        res_found    = '0;
        res_rtx_seq  = '0;
        counter_next = counter_reg;
        if (s1_req_reg == rtc_pkg::REQ_STORE)
        begin
            if (rtc_pkg::store_on(cfg))
            begin
                res_status = rtc_pkg::ST_STORED;
            end
        end
        else if (!slot_entry.valid)
        begin
            res_status = rtc_pkg::ST_EMPTY;
        end
        else if (slot_entry.tag != s1_seq_reg)
        begin
            res_status = rtc_pkg::ST_MISMATCH;
        end
        else
        begin
            res_found = slot_entry.handle;
            if (rtc_pkg::rtx_on(cfg))
            begin
                res_status = rtc_pkg::ST_RETRANSMIT;
                res_rtx_seq = counter_inc;
                if (advance)
                begin
                    counter_next = counter_inc;
                end
            end
            else
            begin
                res_status = rtc_pkg::ST_HIT_NO_RTX;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= rtc_pkg::req_t'(req_type);
            s1_seq_reg <= seq_num;
        end
        if (advance)
        begin
            status_reg  <= res_status;
            found_reg   <= res_found;
            rtx_seq_reg <= res_rtx_seq;
            echo_reg    <= s1_seq_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_handle = found_reg;
    assign rtx_seq_out  = rtx_seq_reg;
    assign echo_seq     = echo_reg;

endmodule

`default_nettype wire

[sv/rtp_retransmit_cache.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache
// Direct-mapped cache of sent media packet handles, looked up on NACK to
// produce retransmissions with an advancing RTX sequence number.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Word
//   input     in         in_valid / in_stall  req_type, seq_num, packet_handle
//   result    out        out_valid/out_stall  status, found_handle,
//                                             rtx_seq_out, echo_seq
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; its result is loaded into the
// output register from the request stage, behind the registered read
// port of the slot memory.
// A store writes its slot at the acceptance edge, so a lookup of the same slot
// accepted after it already sees it.
// After reset a clearing pass walks all CACHE_SLOTS slots, one per cycle, with
// in_stall held high; configuration writes are taken throughout.
// A stalled result holds the request stage, which then raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_retransmit_cache
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rtc_pkg::SSRC_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [rtc_pkg::SEQ_W-1:0]     seq_num,
    input  wire logic [rtc_pkg::HANDLE_W-1:0]  packet_handle,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [rtc_pkg::HANDLE_W-1:0]       found_handle,
    output logic [rtc_pkg::SEQ_W-1:0]          rtx_seq_out,
    output logic [rtc_pkg::SEQ_W-1:0]          echo_seq
);

    rtc_pkg::cfg_t              cfg;
    rtc_pkg::entry_t            wr_entry;
    rtc_pkg::entry_t            slot_entry;
    logic                       clearing;
    logic                       hold;
    logic                       accept;
    logic                       wr_en;
    logic [rtc_pkg::SLOT_W-1:0] slot_addr;

    assign in_stall  = clearing || hold;
    assign accept    = in_valid && !in_stall;
    assign slot_addr = seq_num[rtc_pkg::SLOT_W-1:0];
    assign wr_en     = accept && (rtc_pkg::req_t'(req_type) == rtc_pkg::REQ_STORE)
                       && rtc_pkg::store_on(cfg);

    always_comb
    begin
        wr_entry.valid  = 1'b1;
        wr_entry.tag    = seq_num;
        wr_entry.handle = packet_handle;
    end

    rtc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtc_slot_mem u_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (slot_addr),
        .wr_entry (wr_entry),
        .rd_en    (accept),
        .rd_addr  (slot_addr),
        .rd_entry (slot_entry),
        .clearing (clearing)
    );

    rtc_resolve u_resolve
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .seq_num      (seq_num),
        .slot_entry   (slot_entry),
        .cfg          (cfg),
        .hold         (hold),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_handle (found_handle),
        .rtx_seq_out  (rtx_seq_out),
        .echo_seq     (echo_seq)
    );

endmodule

`default_nettype wire

[sv/rtc_checker.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache port checker
// Checks result words and the retransmit numbering seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [2:0]                   status,
    input wire logic [rtc_pkg::HANDLE_W-1:0] found_handle,
    input wire logic [rtc_pkg::SEQ_W-1:0]    rtx_seq_out,
    input wire logic [rtc_pkg::SEQ_W-1:0]    echo_seq
);

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(found_handle) && $stable(rtx_seq_out) && $stable(echo_seq))
        else $error("result word changed while stalled");

    // Stores, empty slots and mismatches carry no handle and no RTX sequence.
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rtc_pkg::ST_STORED || status == rtc_pkg::ST_SKIPPED
            || status == rtc_pkg::ST_EMPTY || status == rtc_pkg::ST_MISMATCH)
        |-> found_handle == '0 && rtx_seq_out == '0)
        else $error("non-hit result carries a handle or RTX sequence");

    // A hit without RTX leaves the RTX sequence at zero.
    a_hit_no_rtx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rtc_pkg::ST_HIT_NO_RTX |-> rtx_seq_out == '0)
        else $error("RTX sequence given on a hit with RTX off");

    // Back-to-back retransmissions number consecutively.
    a_rtx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status == rtc_pkg::ST_RETRANSMIT)
            ##1 (out_valid && status == rtc_pkg::ST_RETRANSMIT)
        |-> rtx_seq_out == rtc_pkg::SEQ_W'($past(rtx_seq_out) + 1'b1))
        else $error("retransmit sequence did not advance by one");

endmodule

bind rtp_retransmit_cache rtc_checker u_rtc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found_handle (found_handle),
    .rtx_seq_out  (rtx_seq_out),
    .echo_seq     (echo_seq)
);

`default_nettype wire

[tb/rtp_retransmit_cache_tb.sv]
// ----------------------------------------------------------------------------
// RTP retransmit cache testbench
// Drives store and NACK words into the cache under several register settings.
// A shadow copy of the cache predicts every result word, and each one is
// checked field by field in order. A directed table comes first, then
// random phases with idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_retransmit_cache_tb;

    localparam logic [rtc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 64;
    localparam int PHASE_WORDS    = 255;

    typedef struct packed {
        logic [2:0]                   status;
        logic [rtc_pkg::HANDLE_W-1:0] found;
        logic [rtc_pkg::SEQ_W-1:0]    rtx;
        logic [rtc_pkg::SEQ_W-1:0]    echo;
    } cache_reply_t;

    typedef struct packed {
        logic                         is_cfg;
        logic                         nack;
        logic [rtc_pkg::SSRC_W-1:0]   ssrc;
        logic [rtc_pkg::PT_W-1:0]     pt;
        logic                         req;
        logic [rtc_pkg::SEQ_W-1:0]    seq;
        logic [rtc_pkg::HANDLE_W-1:0] handle;
        logic                         pinned;
        cache_reply_t                 pin;
    } dir_row_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [rtc_pkg::SSRC_W-1:0]     cfg_data      = '0;
    logic                           in_valid      = 1'b0;
    logic                           in_stall;
    logic                           req_type      = 1'b0;
    logic [rtc_pkg::SEQ_W-1:0]      seq_num       = '0;
    logic [rtc_pkg::HANDLE_W-1:0]   packet_handle = '0;
    logic                           out_valid;
    logic                           out_stall     = 1'b0;
    logic [2:0]                     status;
    logic [rtc_pkg::HANDLE_W-1:0]   found_handle;
    logic [rtc_pkg::SEQ_W-1:0]      rtx_seq_out;
    logic [rtc_pkg::SEQ_W-1:0]      echo_seq;

    // Typed-in expectation that travels with the word on the input channel.
    logic                           cur_pinned    = 1'b0;
    cache_reply_t                   cur_pin       = '0;

    // Shadow copy of the cache and its registers.
    bit                             shadow_valid  [rtc_pkg::CACHE_SLOTS];
    logic [rtc_pkg::SEQ_W-1:0]      shadow_tag    [rtc_pkg::CACHE_SLOTS];
    logic [rtc_pkg::HANDLE_W-1:0]   shadow_handle [rtc_pkg::CACHE_SLOTS];
    logic [rtc_pkg::SEQ_W-1:0]      shadow_rtx_count = '0;
    logic                           shadow_nack_en   = 1'b0;
    logic [rtc_pkg::SSRC_W-1:0]     shadow_ssrc      = '0;
    logic [rtc_pkg::PT_W-1:0]       shadow_pt        = '0;

    cache_reply_t                   pending_replies[$];
    dir_row_t                       dir_rows[$];
    logic [rtc_pkg::SEQ_W-1:0]      recent_seqs[$];

    int                             error_count = 0;
    int                             idle_cycles = 0;
    int unsigned                    stall_left  = 0;
    bit                             tx_idle     = 1'b1;
    bit                             rx_idle     = 1'b1;
    bit                             hold_req    = 1'b0;

    rtp_retransmit_cache dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .seq_num       (seq_num),
        .packet_handle (packet_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_handle  (found_handle),
        .rtx_seq_out   (rtx_seq_out),
        .echo_seq      (echo_seq)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cache_reply_t predict_cache_reply(
        input logic                         req,
        input logic [rtc_pkg::SEQ_W-1:0]    seq,
        input logic [rtc_pkg::HANDLE_W-1:0] handle);
        cache_reply_t r;
        int           slot;
        logic         rtx_ready;
        r         = '0;
        r.echo    = seq;
        slot      = seq % rtc_pkg::CACHE_SLOTS;
        rtx_ready = (shadow_ssrc != '0) && (shadow_pt != '0);
        if (req == rtc_pkg::REQ_STORE)
        begin
            if (shadow_nack_en && rtx_ready)
            begin
                shadow_valid[slot]  = 1'b1;
                shadow_tag[slot]    = seq;
                shadow_handle[slot] = handle;
                r.status            = rtc_pkg::ST_STORED;
            end
            else
            begin
                r.status = rtc_pkg::ST_SKIPPED;
            end
        end
        else if (!shadow_valid[slot])
        begin
            r.status = rtc_pkg::ST_EMPTY;
        end
        else if (shadow_tag[slot] != seq)
        begin
            r.status = rtc_pkg::ST_MISMATCH;
        end
        else
        begin
            r.found = shadow_handle[slot];
            if (rtx_ready)
            begin
                shadow_rtx_count = shadow_rtx_count + 16'd1;
                r.rtx            = shadow_rtx_count;
                r.status         = rtc_pkg::ST_RETRANSMIT;
            end
            else
            begin
                r.status = rtc_pkg::ST_HIT_NO_RTX;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Result checking, register shadowing and prediction, in that order, so that
    // a word accepted at this edge is never matched against its own result.
    always @(posedge clk)
    begin : monitor
        cache_reply_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result word, expected none, %s %0d echo %0h",
                             $time, "actual status", status, echo_seq);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", want.status, status);
                    check_field("found_handle", want.found, found_handle);
                    check_field("rtx_seq_out", want.rtx, rtx_seq_out);
                    check_field("echo_seq", want.echo, echo_seq);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rtc_pkg::CFG_NACK_ENABLE:      shadow_nack_en = cfg_data[0];
                    rtc_pkg::CFG_RTX_STREAM_ID:    shadow_ssrc    = cfg_data;
                    rtc_pkg::CFG_RTX_PAYLOAD_KIND: shadow_pt      = cfg_data[rtc_pkg::PT_W-1:0];
                    default:                       ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                want = predict_cache_reply(req_type, seq_num, packet_handle);
                if (cur_pinned)
                    want = cur_pin;
                pending_replies.push_back(want);
            end
        end
    end

    // Receiver back-pressure: random bursts, plus one long hold on request.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (rx_idle && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic req, input logic [rtc_pkg::SEQ_W-1:0] seq,
                             input logic [rtc_pkg::HANDLE_W-1:0] handle,
                             input logic pinned, input cache_reply_t pin);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        seq_num       <= seq;
        packet_handle <= handle;
        cur_pinned    <= pinned;
        cur_pin       <= pin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [rtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtc_pkg::SSRC_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Upper data bits carry noise; only the register's own width must land.
    task automatic set_config(input logic ne, input logic [rtc_pkg::SSRC_W-1:0] sid,
                              input logic [rtc_pkg::PT_W-1:0] pt);
        drain_results();
        cfg_write(rtc_pkg::CFG_NACK_ENABLE, ($urandom & 32'hFFFF_FFFE) | ne);
        cfg_write(rtc_pkg::CFG_RTX_STREAM_ID, sid);
        cfg_write(rtc_pkg::CFG_RTX_PAYLOAD_KIND, ($urandom & 32'hFFFF_FF80) | pt);
        cfg_write(CFG_UNMAPPED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic dir_row_t item_row(input logic req,
                                          input logic [rtc_pkg::SEQ_W-1:0] seq,
                                          input logic [rtc_pkg::HANDLE_W-1:0] handle);
        dir_row_t d;
        d        = '0;
        d.req    = req;
        d.seq    = seq;
        d.handle = handle;
        return d;
    endfunction

    function automatic dir_row_t pinned_row(input logic req,
                                            input logic [rtc_pkg::SEQ_W-1:0] seq,
                                            input logic [rtc_pkg::HANDLE_W-1:0] handle,
                                            input logic [2:0] st,
                                            input logic [rtc_pkg::HANDLE_W-1:0] found,
                                            input logic [rtc_pkg::SEQ_W-1:0] rtx);
        dir_row_t d;
        d            = item_row(req, seq, handle);
        d.pinned     = 1'b1;
        d.pin.status = st;
        d.pin.found  = found;
        d.pin.rtx    = rtx;
        d.pin.echo   = seq;
        return d;
    endfunction

    function automatic dir_row_t config_row(input logic ne,
                                            input logic [rtc_pkg::SSRC_W-1:0] sid,
                                            input logic [rtc_pkg::PT_W-1:0] pt);
        dir_row_t d;
        d        = '0;
        d.is_cfg = 1'b1;
        d.nack   = ne;
        d.ssrc   = sid;
        d.pt     = pt;
        return d;
    endfunction

    initial
    begin : stimulus
        dir_row_t                     row;
        cache_reply_t                 none;
        logic                         req;
        logic [rtc_pkg::SEQ_W-1:0]    seq;
        logic [rtc_pkg::HANDLE_W-1:0] hnd;
        logic                         ne;
        logic [rtc_pkg::SSRC_W-1:0]   sid;
        logic [rtc_pkg::PT_W-1:0]     pt;
        int unsigned                  pick;
        int unsigned                  alias_k;

        none = '0;

        // Everything off after reset: lookups find empty slots, stores skip.
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'h0000, 16'h0000,
                                      rtc_pkg::ST_EMPTY, 16'h0, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'hFFFF, 16'hFFFF,
                                      rtc_pkg::ST_EMPTY, 16'h0, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_STORE, 16'h0005, 16'hFFFF,
                                      rtc_pkg::ST_SKIPPED, 16'h0, 16'h0));
        // Fully enabled with the largest register values.
        dir_rows.push_back(config_row(1'b1, 32'hFFFF_FFFF, 7'h7F));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_STORE, 16'h0000, 16'h0000,
                                      rtc_pkg::ST_STORED, 16'h0, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_STORE, 16'hFFFF, 16'hFFFF,
                                      rtc_pkg::ST_STORED, 16'h0, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'h0000, 16'hFFFF,
                                      rtc_pkg::ST_RETRANSMIT, 16'h0, 16'd1));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'hFFFF, 16'h0000,
                                      rtc_pkg::ST_RETRANSMIT, 16'hFFFF, 16'd2));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'd1024, 16'h0,
                                      rtc_pkg::ST_MISMATCH, 16'h0, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'd64511, 16'h0,
                                      rtc_pkg::ST_MISMATCH, 16'h0, 16'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_STORE, 16'd1024, 16'h1234));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'd0, 16'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'd1024, 16'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_STORE, 16'd777, 16'hAAAA));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'd777, 16'h5555));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'd2, 16'h0,
                                      rtc_pkg::ST_EMPTY, 16'h0, 16'h0));
        // RTX stream id zero: no caching, and hits come back without RTX.
        dir_rows.push_back(config_row(1'b1, 32'h0, 7'h7F));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_STORE, 16'd3, 16'h5555,
                                      rtc_pkg::ST_SKIPPED, 16'h0, 16'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'd1024, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_NACK, 16'd3, 16'h0,
                                      rtc_pkg::ST_EMPTY, 16'h0, 16'h0));
        // RTX payload type zero behaves the same way.
        dir_rows.push_back(config_row(1'b1, 32'h1, 7'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'hFFFF, 16'h0));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_STORE, 16'd9, 16'h0,
                                      rtc_pkg::ST_SKIPPED, 16'h0, 16'h0));
        // NACK off: stores skip, but lookups still run on what is cached.
        dir_rows.push_back(config_row(1'b0, 32'h1, 7'h1));
        dir_rows.push_back(pinned_row(rtc_pkg::REQ_STORE, 16'd100, 16'h1,
                                      rtc_pkg::ST_SKIPPED, 16'h0, 16'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'd777, 16'h0));
        dir_rows.push_back(item_row(rtc_pkg::REQ_NACK, 16'd0, 16'h0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
                set_config(row.nack, row.ssrc, row.pt);
            else
                send_item(row.req, row.seq, row.handle, row.pinned, row.pin);
        end

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    ne = 1'b1; sid = 32'hFFFF_FFFF; pt = 7'h7F;
                end
                1:
                begin
                    ne = 1'b1; sid = $urandom | 32'h1; pt = 7'($urandom_range(1, 127));
                end
                2:
                begin
                    ne = 1'b1; sid = $urandom; pt = 7'h0;
                end
                3:
                begin
                    ne = 1'b0; sid = $urandom; pt = 7'($urandom_range(0, 127));
                end
                4:
                begin
                    ne = 1'b1; sid = 32'h1; pt = 7'h1;
                end
                default:
                begin
                    ne  = ($urandom_range(0, 3) != 0);
                    sid = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
                    pt  = 7'($urandom_range(0, 127));
                end
            endcase
            tx_idle = (p != 1) && (p != 5);
            rx_idle = (p != 5);
            set_config(ne, sid, pt);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Sender waits for every result once; receiver holds off once while
                // the sender keeps offering words.
                if (p == 0 && n == PHASE_WORDS / 2)
                    drain_results();
                if (p == 1 && n == 64)
                    hold_req = 1'b1;

                pick = $urandom_range(0, 9);
                hnd  = 16'($urandom);
                if (pick < 4 || recent_seqs.size() == 0)
                begin
                    req = rtc_pkg::REQ_STORE;
                    if ($urandom_range(0, 1) != 0)
                        seq = 16'($urandom);
                    else
                        seq = 16'(16'h8000 + $urandom_range(0, 4095));
                    recent_seqs.push_back(seq);
                    if (recent_seqs.size() > 32)
                        void'(recent_seqs.pop_front());
                end
                else if (pick < 8)
                begin
                    req = rtc_pkg::REQ_NACK;
                    seq = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
                end
                else if (pick == 8)
                begin
                    // Same slot as a cached sequence, different tag.
                    req     = rtc_pkg::REQ_NACK;
                    alias_k = $urandom_range(1, 63);
                    seq     = 16'(recent_seqs[$urandom_range(0, recent_seqs.size() - 1)]
                                  + alias_k * rtc_pkg::CACHE_SLOTS);
                end
                else
                begin
                    req = rtc_pkg::REQ_NACK;
                    seq = 16'($urandom);
                end
                send_item(req, seq, hnd, 1'b0, none);
            end
        end

        drain_results();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
sv/rtc_pkg.sv
sv/rtc_cfg_regs.sv
sv/rtc_slot_mem.sv
sv/rtc_resolve.sv
sv/rtp_retransmit_cache.sv
sv/rtc_checker.sv
tb/rtp_retransmit_cache_tb.sv
